[rtl/core/brbq_pkg.sv]
// ---------------------------------------------------------------------------
// brbq_pkg
// Shared types, codes and stream field layout of the byte ring buffer queue.
// ---------------------------------------------------------------------------
package brbq_pkg;

    localparam int CNT_W      = 11;
    localparam int SUM_W      = CNT_W + 1;
    localparam int BURST_W    = 64;
    localparam int BYTE_SEL_W = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd1024;

    // s_tdata: burst_bytes then length
    localparam int S_BURST_LSB = 0;
    localparam int S_LEN_LSB   = S_BURST_LSB + BURST_W;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 2;

    // m_tdata: status, popped_byte, accepted_count, fill_level, is_empty
    localparam int STATUS_W    = 3;
    localparam int M_STAT_LSB  = 0;
    localparam int M_POP_LSB   = M_STAT_LSB + STATUS_W;
    localparam int M_ACC_LSB   = M_POP_LSB + 8;
    localparam int M_FILL_LSB  = M_ACC_LSB + CNT_W;
    localparam int M_EMPTY_LSB = M_FILL_LSB + CNT_W;
    localparam int M_USED_W    = M_EMPTY_LSB + 1;
    localparam int M_TDATA_W   = 40;

    localparam logic PADDR_REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_POP     = 2'd1,
        CMD_DISCARD = 2'd2,
        CMD_IGNORE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_NO_ROOM   = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_OVER_FILL = 3'd3,
        STAT_TOO_LONG  = 3'd4
    } status_t;

endpackage

[rtl/core/brbq_ram.sv]
// ---------------------------------------------------------------------------
// brbq_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module brbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/byte_ring_buffer_queue_unit.sv]
// ---------------------------------------------------------------------------
// byte_ring_buffer_queue_unit
// Circular byte queue with a configurable ring size and burst enqueue.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the kind (enqueue,
//   pop, discard), s_tdata the burst bytes and the length. Each request
//   gives exactly one result on the m_ stream with status, popped byte,
//   accepted count, fill level and empty flag.
//   The APB port holds the capacity register at address 0; a write flushes
//   the queue but leaves the stored bytes. Write it only while idle.
//   One request is worked at a time. A pop, discard, rejected or empty
//   request passes through EXEC and RESULT before the next acceptance;
//   an enqueue of n bytes passes through WRITE as well, as the byte store
//   has one write port and takes one byte per cycle.
//   The result sits in an output register: while the receiver stalls the
//   next request is still taken and worked, and its result waits until the
//   register frees.
//   Reset empties the queue and sets the capacity to 1024; the byte store
//   is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module byte_ring_buffer_queue_unit #(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_BURST   = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] burst_bytes, [74:64] length
    input  logic [brbq_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] cmd
    input  logic [brbq_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] status, [10:3] popped_byte, [21:11] accepted_count,
    // [32:22] fill_level, [33] is_empty
    output logic [brbq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brbq_pkg::PADDR_W-1:0]     paddr,
    input  logic [brbq_pkg::PDATA_W-1:0]     pwdata,
    output logic [brbq_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int IDX_W    = $clog2(STORE_DEPTH);
    localparam int SIZE_MAX = (STORE_DEPTH > 2047) ? 2047 : STORE_DEPTH;
    localparam int BCNT_W   = $clog2(MAX_BURST + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRITE,
        ST_RESULT
    } state_t;

    state_t                           state_reg;
    logic [brbq_pkg::CNT_W-1:0]       cap_reg;
    logic [IDX_W-1:0]                 ridx_reg, ridx_next;
    logic [IDX_W-1:0]                 widx_reg, widx_next;
    logic [brbq_pkg::CNT_W-1:0]       held_reg, held_next;
    logic [BCNT_W-1:0]                bcnt_reg;
    brbq_pkg::cmd_t                   cmd_reg;
    logic [brbq_pkg::BURST_W-1:0]     burst_reg;
    logic [brbq_pkg::CNT_W-1:0]       len_reg;
    brbq_pkg::status_t                status_reg, status_next;
    logic [brbq_pkg::CNT_W-1:0]       acc_reg, acc_next;
    logic                             pop_reg, pop_next;
    logic                             m_tvalid_reg;
    logic [brbq_pkg::M_TDATA_W-1:0]   m_tdata_reg;

    logic [brbq_pkg::CNT_W-1:0]       ring_size;
    logic [brbq_pkg::SUM_W-1:0]       size_ext;
    logic [brbq_pkg::SUM_W-1:0]       rd_sum, wr_sum;
    logic [brbq_pkg::SUM_W-1:0]       rd_step;
    logic                             cfg_wr;
    logic                             ram_wr_en, ram_rd_en;
    logic [7:0]                       ram_wr_data, ram_rd_data;
    logic [7:0]                       popped_byte;
    logic                             write_last;

    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == brbq_pkg::PADDR_REG_CAPACITY);

    always_comb begin
        if (cap_reg == '0) begin
            ring_size = brbq_pkg::CNT_W'(1);
        end else if (cap_reg > brbq_pkg::CNT_W'(SIZE_MAX)) begin
            ring_size = brbq_pkg::CNT_W'(SIZE_MAX);
        end else begin
            ring_size = cap_reg;
        end
    end

    assign size_ext = brbq_pkg::SUM_W'(ring_size);

    // Decision and index update for the request held in EXEC
    always_comb begin
        status_next = brbq_pkg::STAT_OK;
        acc_next    = '0;
        pop_next    = 1'b0;
        held_next   = held_reg;
        rd_step     = '0;
        ram_rd_en   = 1'b0;
        case (cmd_reg)
            brbq_pkg::CMD_ENQUEUE: begin
                if (len_reg > brbq_pkg::CNT_W'(MAX_BURST)) begin
                    status_next = brbq_pkg::STAT_TOO_LONG;
                end else if (brbq_pkg::SUM_W'(held_reg) + brbq_pkg::SUM_W'(len_reg)
                             > size_ext) begin
                    status_next = brbq_pkg::STAT_NO_ROOM;
                end else begin
                    acc_next  = len_reg;
                    held_next = held_reg + len_reg;
                end
            end
            brbq_pkg::CMD_POP: begin
                if (held_reg == '0) begin
                    status_next = brbq_pkg::STAT_EMPTY;
                end else begin
                    acc_next  = brbq_pkg::CNT_W'(1);
                    held_next = held_reg - brbq_pkg::CNT_W'(1);
                    pop_next  = 1'b1;
                    rd_step   = brbq_pkg::SUM_W'(1);
                    ram_rd_en = (state_reg == ST_EXEC);
                end
            end
            brbq_pkg::CMD_DISCARD: begin
                if (len_reg > held_reg) begin
                    status_next = brbq_pkg::STAT_OVER_FILL;
                end else begin
                    acc_next  = len_reg;
                    held_next = held_reg - len_reg;
                    rd_step   = brbq_pkg::SUM_W'(len_reg);
                end
            end
            default: begin
                status_next = brbq_pkg::STAT_OK;
            end
        endcase
    end

    always_comb begin
        rd_sum = brbq_pkg::SUM_W'(ridx_reg) + rd_step;
        if (rd_sum >= size_ext) begin
            rd_sum = rd_sum - size_ext;
        end
        ridx_next = IDX_W'(rd_sum);

        wr_sum = brbq_pkg::SUM_W'(widx_reg) + brbq_pkg::SUM_W'(1);
        if (wr_sum >= size_ext) begin
            wr_sum = wr_sum - size_ext;
        end
        widx_next = IDX_W'(wr_sum);
    end

    assign write_last  = (brbq_pkg::CNT_W'(bcnt_reg) + brbq_pkg::CNT_W'(1)) == len_reg;
    assign ram_wr_en   = (state_reg == ST_WRITE);
    assign ram_wr_data = burst_reg[8 * brbq_pkg::BYTE_SEL_W'(bcnt_reg) +: 8];
    assign popped_byte = pop_reg ? ram_rd_data : 8'd0;

    brbq_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (widx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ridx_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= brbq_pkg::CAPACITY_RESET;
            ridx_reg     <= '0;
            widx_reg     <= '0;
            held_reg     <= '0;
            bcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                cap_reg  <= pwdata[brbq_pkg::CNT_W-1:0];
                ridx_reg <= '0;
                widx_reg <= '0;
                held_reg <= '0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= brbq_pkg::cmd_t'(s_tuser[1:0]);
                        burst_reg <= s_tdata[brbq_pkg::S_BURST_LSB +: brbq_pkg::BURST_W];
                        len_reg   <= s_tdata[brbq_pkg::S_LEN_LSB +: brbq_pkg::CNT_W];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    status_reg <= status_next;
                    acc_reg    <= acc_next;
                    pop_reg    <= pop_next;
                    held_reg   <= held_next;
                    ridx_reg   <= ridx_next;
                    bcnt_reg   <= '0;
                    if (cmd_reg == brbq_pkg::CMD_ENQUEUE && status_next == brbq_pkg::STAT_OK
                        && len_reg != '0) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_WRITE: begin
                    widx_reg <= widx_next;
                    bcnt_reg <= bcnt_reg + BCNT_W'(1);
                    if (write_last) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= brbq_pkg::M_TDATA_W'({
                            (held_reg == '0), held_reg, acc_reg, popped_byte, status_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign prdata   = (paddr[2] == brbq_pkg::PADDR_REG_CAPACITY) ?
                      brbq_pkg::PDATA_W'(cap_reg) : '0;
    assign pready   = 1'b1;

endmodule

[rtl/core/brbq_checker.sv]
// ---------------------------------------------------------------------------
// brbq_checker
// Port-level checks on the result stream of the byte ring buffer queue.
// ---------------------------------------------------------------------------
module brbq_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [brbq_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [brbq_pkg::STATUS_W-1:0] res_status;
    logic [7:0]                    res_popped;
    logic [brbq_pkg::CNT_W-1:0]    res_acc;
    logic [brbq_pkg::CNT_W-1:0]    res_fill;
    logic                          res_empty;

    assign res_status = m_tdata[brbq_pkg::M_STAT_LSB +: brbq_pkg::STATUS_W];
    assign res_popped = m_tdata[brbq_pkg::M_POP_LSB +: 8];
    assign res_acc    = m_tdata[brbq_pkg::M_ACC_LSB +: brbq_pkg::CNT_W];
    assign res_fill   = m_tdata[brbq_pkg::M_FILL_LSB +: brbq_pkg::CNT_W];
    assign res_empty  = m_tdata[brbq_pkg::M_EMPTY_LSB];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_error_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status != brbq_pkg::STAT_OK |-> res_acc == '0 && res_popped == 8'd0)
        else $error("rejected request reports a count or byte");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_empty == (res_fill == '0))
        else $error("empty flag disagrees with fill level");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status == brbq_pkg::STAT_EMPTY |-> res_fill == '0)
        else $error("pop refused with bytes held");

endmodule

bind byte_ring_buffer_queue_unit brbq_checker u_brbq_checker (.*);

[verif/tb_byte_ring_buffer_queue_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_byte_ring_buffer_queue_unit
// Self-checking bench for the circular byte queue. Directed requests cover the
// empty, full, wrap, oversize and unused-command cases. Random request streams
// then run at several ring capacities under shifting sender and receiver
// stalls, and one long output hold-off. Each request's result is predicted on
// acceptance and compared field by field as the result leaves the block.
// ---------------------------------------------------------------------------
module tb_byte_ring_buffer_queue_unit;

    localparam int RING_DEPTH    = 1024;
    localparam int BURST_LIMIT   = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PRINT_LIMIT   = 50;
    localparam logic [brbq_pkg::PADDR_W-1:0] CAPACITY_ADDR = 3'd0;

    typedef struct {
        brbq_pkg::status_t          status;
        logic [7:0]                 popped;
        logic [brbq_pkg::CNT_W-1:0] accepted;
        logic [brbq_pkg::CNT_W-1:0] fill;
        logic                       empty;
    } result_t;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [brbq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [brbq_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [brbq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [brbq_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [brbq_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [brbq_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    logic [7:0]                 ring_bytes [RING_DEPTH];
    int unsigned                head_idx     = 0;
    int unsigned                tail_idx     = 0;
    int unsigned                bytes_held   = 0;
    logic [brbq_pkg::CNT_W-1:0] capacity_reg = brbq_pkg::CAPACITY_RESET;
    result_t                    pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    byte_ring_buffer_queue_unit #(
        .STORE_DEPTH (RING_DEPTH),
        .MAX_BURST   (BURST_LIMIT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // hold the receiver off while a stretch is requested, else stall at random
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned effective_ring_size();
        int unsigned size;
        size = 32'(capacity_reg);
        if (size == 0) size = 1;
        if (size > RING_DEPTH) size = RING_DEPTH;
        return size;
    endfunction

    function automatic int unsigned step_index(int unsigned idx, int unsigned n,
                                               int unsigned size);
        int unsigned v;
        v = idx + n;
        if (v >= size) v -= size;
        return v;
    endfunction

    function automatic result_t queue_request(brbq_pkg::cmd_t kind,
                                              logic [brbq_pkg::BURST_W-1:0] burst,
                                              logic [brbq_pkg::CNT_W-1:0] len);
        result_t     r;
        int unsigned size;
        int unsigned i;
        size       = effective_ring_size();
        r.status   = brbq_pkg::STAT_OK;
        r.popped   = '0;
        r.accepted = '0;
        case (kind)
            brbq_pkg::CMD_ENQUEUE: begin
                if (len > BURST_LIMIT) begin
                    r.status = brbq_pkg::STAT_TOO_LONG;
                end else if (bytes_held + len > size) begin
                    r.status = brbq_pkg::STAT_NO_ROOM;
                end else begin
                    for (i = 0; i < len; i++) begin
                        ring_bytes[tail_idx % RING_DEPTH] = burst[8*i +: 8];
                        tail_idx = step_index(tail_idx, 1, size);
                    end
                    bytes_held += len;
                    r.accepted = len;
                end
            end
            brbq_pkg::CMD_POP: begin
                if (bytes_held == 0) begin
                    r.status = brbq_pkg::STAT_EMPTY;
                end else begin
                    r.popped   = ring_bytes[head_idx % RING_DEPTH];
                    head_idx   = step_index(head_idx, 1, size);
                    bytes_held -= 1;
                    r.accepted = brbq_pkg::CNT_W'(1);
                end
            end
            brbq_pkg::CMD_DISCARD: begin
                if (len > bytes_held) begin
                    r.status = brbq_pkg::STAT_OVER_FILL;
                end else begin
                    head_idx   = step_index(head_idx, len, size);
                    bytes_held -= len;
                    r.accepted = len;
                end
            end
            default: ;
        endcase
        r.fill  = brbq_pkg::CNT_W'(bytes_held);
        r.empty = (bytes_held == 0);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("[%0t] %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        result_t                        want;
        logic [brbq_pkg::M_TDATA_W-1:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding", got));
            end else begin
                want = pending_results.pop_front();
                if (got[brbq_pkg::M_STAT_LSB +: brbq_pkg::STATUS_W] !== want.status)
                    report_mismatch($sformatf("status: got %0d, expected %0d",
                        got[brbq_pkg::M_STAT_LSB +: brbq_pkg::STATUS_W], want.status));
                if (got[brbq_pkg::M_POP_LSB +: 8] !== want.popped)
                    report_mismatch($sformatf("popped byte: got %h, expected %h",
                        got[brbq_pkg::M_POP_LSB +: 8], want.popped));
                if (got[brbq_pkg::M_ACC_LSB +: brbq_pkg::CNT_W] !== want.accepted)
                    report_mismatch($sformatf("accepted count: got %0d, expected %0d",
                        got[brbq_pkg::M_ACC_LSB +: brbq_pkg::CNT_W], want.accepted));
                if (got[brbq_pkg::M_FILL_LSB +: brbq_pkg::CNT_W] !== want.fill)
                    report_mismatch($sformatf("fill level: got %0d, expected %0d",
                        got[brbq_pkg::M_FILL_LSB +: brbq_pkg::CNT_W], want.fill));
                if (got[brbq_pkg::M_EMPTY_LSB] !== want.empty)
                    report_mismatch($sformatf("empty flag: got %b, expected %b",
                        got[brbq_pkg::M_EMPTY_LSB], want.empty));
            end
        end
    end

    task automatic send_request(brbq_pkg::cmd_t kind, logic [brbq_pkg::BURST_W-1:0] burst,
                                logic [brbq_pkg::CNT_W-1:0] len);
        logic [brbq_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[brbq_pkg::S_BURST_LSB +: brbq_pkg::BURST_W] = burst;
        word[brbq_pkg::S_LEN_LSB +: brbq_pkg::CNT_W]     = len;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(queue_request(kind, burst, len));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic finish_burst();
        stop_sending();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [brbq_pkg::CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= brbq_pkg::PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        capacity_reg = value;
        head_idx     = 0;
        tail_idx     = 0;
        bytes_held   = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== brbq_pkg::PDATA_W'(value))
            report_mismatch($sformatf("capacity readback: got %0d, expected %0d",
                                      prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_request(output bit counted);
        int unsigned                  pick;
        int unsigned                  limit;
        logic [brbq_pkg::BURST_W-1:0] burst;
        logic [brbq_pkg::CNT_W-1:0]   len;
        brbq_pkg::cmd_t               kind;
        burst = {$urandom, $urandom};
        len   = brbq_pkg::CNT_W'($urandom_range(0, 2047));
        pick  = $urandom_range(99);
        limit = (bytes_held > 16) ? 16 : bytes_held;
        if (pick < 45) begin
            kind = brbq_pkg::CMD_ENQUEUE;
            len  = brbq_pkg::CNT_W'($urandom_range(0, BURST_LIMIT));
        end else if (pick < 65) begin
            kind = brbq_pkg::CMD_POP;
        end else if (pick < 80) begin
            kind = brbq_pkg::CMD_DISCARD;
            len  = brbq_pkg::CNT_W'($urandom_range(0, limit));
        end else if (pick < 85) begin
            kind = brbq_pkg::CMD_DISCARD;
            len  = brbq_pkg::CNT_W'($urandom_range(0, bytes_held));
        end else if (pick < 92) begin
            kind = brbq_pkg::CMD_ENQUEUE;
        end else if (pick < 96) begin
            kind = brbq_pkg::CMD_DISCARD;
        end else begin
            kind = brbq_pkg::CMD_IGNORE;
        end
        send_request(kind, burst, len);
        counted = (kind != brbq_pkg::CMD_IGNORE);
    endtask

    task automatic test_directed_requests();
        send_request(brbq_pkg::CMD_POP, '0, '0);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd1);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd0);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd0);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd9);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd2047);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd8);
        send_request(brbq_pkg::CMD_ENQUEUE, '0, 11'd8);
        send_request(brbq_pkg::CMD_IGNORE, '1, 11'd2047);
        send_request(brbq_pkg::CMD_POP, '1, 11'd2047);
        send_request(brbq_pkg::CMD_DISCARD, '1, 11'd2047);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd14);
        send_request(brbq_pkg::CMD_POP, '0, '0);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'h0123_4567_89ab_cda5, 11'd1);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd1);
        finish_burst();
    endtask

    task automatic test_small_ring_wrap();
        write_capacity(11'd3);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'h5555_5555_55c3_b2a1, 11'd3);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'h0000_0000_0000_00d4, 11'd1);
        send_request(brbq_pkg::CMD_POP, '0, '0);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'haaaa_aaaa_aaaa_aae5, 11'd1);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd3);
        finish_burst();
        // a zero capacity behaves as a one-byte ring
        write_capacity(11'd0);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'hffff_ffff_ffff_ff7e, 11'd1);
        send_request(brbq_pkg::CMD_ENQUEUE, 64'h0000_0000_0000_0081, 11'd1);
        send_request(brbq_pkg::CMD_POP, '0, '0);
        finish_burst();
    endtask

    task automatic test_random_traffic(logic [brbq_pkg::CNT_W-1:0] capacity, int count);
        int sent;
        bit counted;
        sent = 0;
        write_capacity(capacity);
        while (sent < count) begin
            send_random_request(counted);
            if (counted) sent++;
            if (counted && sent == count / 2) begin
                stop_sending();
                wait_results_drained();
            end
        end
        finish_burst();
    endtask

    task automatic test_full_ring();
        int i;
        // a capacity above the store depth works as the full store
        write_capacity(11'd1025);
        for (i = 0; i < RING_DEPTH / BURST_LIMIT; i++)
            send_request(brbq_pkg::CMD_ENQUEUE, {$urandom, $urandom}, 11'd8);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd1);
        send_request(brbq_pkg::CMD_ENQUEUE, '1, 11'd0);
        for (i = 0; i < 4; i++)
            send_request(brbq_pkg::CMD_POP, '0, '0);
        send_request(brbq_pkg::CMD_ENQUEUE, {$urandom, $urandom}, 11'd4);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'd2047);
        send_request(brbq_pkg::CMD_DISCARD, '0, 11'(bytes_held - 1));
        send_request(brbq_pkg::CMD_POP, '0, '0);
        finish_burst();
    endtask

    task automatic test_output_backpressure();
        int sent;
        bit counted;
        sent = 0;
        hold_off_left = 300;
        while (sent < 40) begin
            send_random_request(counted);
            if (counted) sent++;
        end
        finish_burst();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 63;
        test_directed_requests();
        test_small_ring_wrap();
        test_random_traffic(11'd1024, 60);
        test_random_traffic(11'd5, 60);

        send_idle_pct = 63;
        recv_idle_pct = 21;
        test_random_traffic(11'd0, 60);
        test_random_traffic(11'd2047, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(11'd1, 60);
        test_random_traffic(11'd9, 60);
        test_full_ring();
        test_output_backpressure();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
